// ===== design/three_axis_position_pid_macros.svh =====
// Assertion macros for the three-axis position PID.
// Included by the top level; assertions vanish when ASSERT_OFF is defined.
`ifndef THREE_AXIS_POSITION_PID_MACROS_SVH
`define THREE_AXIS_POSITION_PID_MACROS_SVH
`ifndef ASSERT_OFF
`define TAPP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define TAPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TAPP_ASSERT(lbl, cond, msg)
`define TAPP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/tapp_pkg.sv =====
// Shared types and constants of the three-axis position PID.
// No dependencies; imported by every module of the block.
package tapp_pkg;

  localparam int GAIN_BITS  = 8;
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 20;

  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KP    = 3'd0;
  localparam logic [2:0] CFG_KI    = 3'd1;
  localparam logic [2:0] CFG_KD    = 3'd2;
  localparam logic [2:0] CFG_ALPHA = 3'd3;
  localparam logic [2:0] CFG_AWL   = 3'd4;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ERR, OP_MF1, OP_MF2, OP_FILT, OP_INT, OP_DLIM,
    OP_CLAMP, OP_MI, OP_MD, OP_DD, OP_SUM, OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic ki_zero;
    logic dt_zero;
    logic div_busy;
  } dp_stat_t;

endpackage

// ===== design/tapp_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on tapp_pkg for the operand widths.
module tapp_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tapp_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [tapp_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           busy,
  output logic [tapp_pkg::DIVIDEND_W-1:0] quotient
);
  import tapp_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt, dsr_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    fits    = trial >= {1'b0, dsr_r};
    rem_nxt = fits ? DIVISOR_W'(trial - {1'b0, dsr_r}) : trial[DIVISOR_W-1:0];
    quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIVIDEND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== design/tapp_dp.sv =====
// Datapath of the three-axis position PID: registers, shared multiplier, divider.
// Depends on tapp_pkg and tapp_div; driven by tapp_ctrl, one operation a cycle except while it waits.
module tapp_dp #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tapp_pkg::dp_cmd_t   cmd,
  output tapp_pkg::dp_stat_t  stat,
  input  logic                cfg_write_en,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  input  logic                in_command,
  input  logic signed [31:0]  in_target_x,
  input  logic signed [31:0]  in_target_y,
  input  logic signed [31:0]  in_target_z,
  input  logic signed [31:0]  in_measured_x,
  input  logic signed [31:0]  in_measured_y,
  input  logic signed [31:0]  in_measured_z,
  input  logic [19:0]         in_time_step,
  output logic signed [31:0]  out_speed_x,
  output logic signed [31:0]  out_speed_y,
  output logic signed [31:0]  out_speed_z,
  output logic                out_saturated
);
  import tapp_pkg::*;

  localparam int DSHIFT = FRACTION_BITS - GAIN_BITS;

  // Configuration registers.
  logic [47:0] kp_r, ki_r, kd_r;
  logic [16:0] alpha_r;
  logic [30:0] awl_r;

  // Captured item and controller state.
  logic signed [31:0] tgt_r [3];
  logic signed [31:0] meas_r [3];
  logic [19:0]        dt_r;
  logic               primed_r, prime_now_r;
  logic signed [31:0] prev_r [3];
  logic signed [31:0] filt_r [3];
  logic signed [47:0] integ_r [3];

  // Working registers.
  logic signed [31:0] e_r;
  logic signed [50:0] acc_r;
  logic signed [69:0] prod_r;
  logic signed [47:0] s_r;
  logic signed [40:0] p_r;
  logic signed [56:0] acc2_r;
  logic               dneg_r;
  logic signed [31:0] speed_r [3];
  logic               sat_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic               out_sat_r;

  logic [1:0]            ax;
  logic [15:0]           kp_g, ki_g, kd_g;
  logic [16:0]           alpha_eff, alpha_cmp;
  logic signed [32:0]    diff33;
  logic signed [31:0]    e_val;
  logic signed [20:0]    mul_a;
  logic signed [48:0]    mul_b;
  logic signed [51:0]    fsum, frnd;
  logic signed [52:0]    erd;
  logic signed [63:0]    isum;
  logic signed [47:0]    lim, s_clamp;
  logic signed [47:0]    num_mag;
  logic signed [56:0]    i_rnd;
  logic [60:0]           qc;
  logic signed [61:0]    dval;
  logic signed [63:0]    total;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend, div_q;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_busy;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh00007FFFFFFFFFFF) begin
      return 48'sh7FFFFFFFFFFF;
    end else if (v < -64'sh0000800000000000) begin
      return 48'sh800000000000;
    end
    return v[47:0];
  endfunction

  tapp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Per-axis selections and the error of the current axis.
  always_comb begin
    ax        = cmd.axis;
    kp_g      = kp_r[16*ax +: 16];
    ki_g      = ki_r[16*ax +: 16];
    kd_g      = kd_r[16*ax +: 16];
    alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    alpha_cmp = 17'(ALPHA_ONE - alpha_eff);
    diff33    = 33'(tgt_r[ax]) - 33'(meas_r[ax]);
    e_val     = sat32(64'(diff33));
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MF1: begin
        mul_a = $signed({4'b0, alpha_eff});
        mul_b = 49'(33'(e_r) - 33'(prev_r[ax]));
      end
      OP_MF2: begin
        mul_a = $signed({4'b0, alpha_cmp});
        mul_b = 49'(filt_r[ax]);
      end
      OP_FILT: begin
        mul_a = $signed({1'b0, dt_r});
        mul_b = 49'(e_r);
      end
      OP_INT: begin
        mul_a = $signed({5'b0, kp_g});
        mul_b = 49'(e_r);
      end
      OP_MI: begin
        mul_a = $signed({5'b0, ki_g});
        mul_b = 49'(s_r);
      end
      OP_MD: begin
        mul_a = $signed({5'b0, kd_g});
        mul_b = 49'(filt_r[ax]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounding, saturation and clamp arithmetic on the registered product.
  always_comb begin
    fsum    = 52'(acc_r) + 52'($signed(prod_r[50:0]));
    frnd    = (fsum + 52'sd32768) >>> 16;
    erd     = ($signed(prod_r[52:0]) + (53'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    isum    = 64'(integ_r[ax]) + 64'(erd);
    lim     = $signed({9'b0, div_q[38:0]});
    s_clamp = s_r;
    if (!stat.ki_zero) begin
      if (s_r > lim) begin
        s_clamp = lim;
      end else if (s_r < -lim) begin
        s_clamp = -lim;
      end
    end
    i_rnd   = 57'(($signed(prod_r[64:0]) + 65'sd128) >>> GAIN_BITS);
    num_mag = prod_r[48] ? 48'(-$signed(prod_r[48:0])) : prod_r[47:0];
    qc      = (div_q > 64'h1000_0000_0000_0000) ? 61'h1000_0000_0000_0000 : div_q[60:0];
    dval    = dneg_r ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    if (dt_r == '0) begin
      dval = '0;
    end
    total   = 64'(acc2_r) + 64'(dval);
  end

  // Divider operands: the anti-windup limit or the derivative quotient.
  always_comb begin
    div_start    = (cmd.op == OP_DLIM) || (cmd.op == OP_DD);
    div_dividend = {25'b0, awl_r, 8'b0};
    div_divisor  = {4'b0, ki_g};
    if (cmd.op == OP_DD) begin
      div_dividend = {16'b0, num_mag} << DSHIFT;
      div_divisor  = dt_r;
    end
  end

  // Configuration and persistent controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= '0;
      ki_r     <= '0;
      kd_r     <= '0;
      alpha_r  <= ALPHA_ONE;
      awl_r    <= '0;
      primed_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i]  <= '0;
        filt_r[i]  <= '0;
        integ_r[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_KP:    kp_r    <= cfg_data;
          CFG_KI:    ki_r    <= cfg_data;
          CFG_KD:    kd_r    <= cfg_data;
          CFG_ALPHA: alpha_r <= cfg_data[16:0];
          CFG_AWL:   awl_r   <= cfg_data[30:0];
          default:   ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          if (in_command) begin
            for (int i = 0; i < 3; i++) begin
              integ_r[i] <= '0;
            end
          end else begin
            primed_r <= 1'b1;
          end
        end
        OP_ERR: begin
          if (prime_now_r) begin
            prev_r[ax] <= e_val;
            filt_r[ax] <= e_val;
          end
        end
        OP_FILT: begin
          filt_r[ax] <= sat32(64'(frnd));
          prev_r[ax] <= e_r;
        end
        OP_CLAMP: integ_r[ax] <= s_clamp;
        default: ;
      endcase
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        tgt_r[0]    <= in_target_x;
        tgt_r[1]    <= in_target_y;
        tgt_r[2]    <= in_target_z;
        meas_r[0]   <= in_measured_x;
        meas_r[1]   <= in_measured_y;
        meas_r[2]   <= in_measured_z;
        dt_r        <= in_time_step;
        prime_now_r <= !primed_r;
        sat_r       <= 1'b0;
      end
      OP_ERR: e_r <= e_val;
      OP_MF1: prod_r <= 70'(mul_a * mul_b);
      OP_MF2: begin
        acc_r  <= $signed(prod_r[50:0]);
        prod_r <= 70'(mul_a * mul_b);
      end
      OP_FILT: prod_r <= 70'(mul_a * mul_b);
      OP_INT: begin
        s_r    <= sat48(isum);
        prod_r <= 70'(mul_a * mul_b);
      end
      OP_CLAMP: begin
        s_r <= s_clamp;
        p_r <= 41'(($signed(prod_r[48:0]) + 49'sd128) >>> GAIN_BITS);
      end
      OP_MI: prod_r <= 70'(mul_a * mul_b);
      OP_MD: begin
        acc2_r <= 57'(p_r) + i_rnd;
        prod_r <= 70'(mul_a * mul_b);
      end
      OP_DD: dneg_r <= prod_r[48];
      OP_SUM: begin
        speed_r[ax] <= sat32(total);
        if (total > 64'sd2147483647 || total < -64'sd2147483648) begin
          sat_r <= 1'b1;
        end
      end
      OP_PUBLISH: begin
        out_x_r   <= speed_r[0];
        out_y_r   <= speed_r[1];
        out_z_r   <= speed_r[2];
        out_sat_r <= sat_r;
      end
      default: ;
    endcase
  end

  assign stat.ki_zero  = (ki_g == '0);
  assign stat.dt_zero  = (dt_r == '0);
  assign stat.div_busy = div_busy;

  assign out_speed_x   = out_x_r;
  assign out_speed_y   = out_y_r;
  assign out_speed_z   = out_z_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== design/tapp_ctrl.sv =====
// Controller of the three-axis position PID: sequences the datapath per axis.
// Depends on tapp_pkg for the command and status structs.
module tapp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_command,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tapp_pkg::dp_stat_t stat,
  output tapp_pkg::dp_cmd_t  cmd
);
  import tapp_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_ERR      = 15'b000000000000010,
    S_MF1      = 15'b000000000000100,
    S_MF2      = 15'b000000000001000,
    S_FILT     = 15'b000000000010000,
    S_INT      = 15'b000000000100000,
    S_LIM_GO   = 15'b000000001000000,
    S_LIM_WAIT = 15'b000000010000000,
    S_CLAMP    = 15'b000000100000000,
    S_MI       = 15'b000001000000000,
    S_MD       = 15'b000010000000000,
    S_D_GO     = 15'b000100000000000,
    S_D_WAIT   = 15'b001000000000000,
    S_SUM      = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state and the datapath operation of each state.
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.axis      = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (!in_command) begin
            state_nxt = S_ERR;
            axis_nxt  = 2'd0;
          end
        end
      end
      S_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = S_MF1;
      end
      S_MF1: begin
        cmd.op    = OP_MF1;
        state_nxt = S_MF2;
      end
      S_MF2: begin
        cmd.op    = OP_MF2;
        state_nxt = S_FILT;
      end
      S_FILT: begin
        cmd.op    = OP_FILT;
        state_nxt = S_INT;
      end
      S_INT: begin
        cmd.op    = OP_INT;
        state_nxt = stat.ki_zero ? S_CLAMP : S_LIM_GO;
      end
      S_LIM_GO: begin
        cmd.op    = OP_DLIM;
        state_nxt = S_LIM_WAIT;
      end
      S_LIM_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.op    = OP_CLAMP;
        state_nxt = S_MI;
      end
      S_MI: begin
        cmd.op    = OP_MI;
        state_nxt = S_MD;
      end
      S_MD: begin
        cmd.op    = OP_MD;
        state_nxt = stat.dt_zero ? S_SUM : S_D_GO;
      end
      S_D_GO: begin
        cmd.op    = OP_DD;
        state_nxt = S_D_WAIT;
      end
      S_D_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.op = OP_SUM;
        if (axis_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_ERR;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/three_axis_position_pid.sv =====
// Three-axis position PID: one control step loads the item, then per axis runs the
// error, filter and integrator operations, a pass of the shared radix-2 divider
// for the anti-windup limit, the clamp and gain products, a second divider pass
// for the derivative quotient and the sum, then publishes the result. A pass is
// skipped when that axis's Ki or the step's dt is zero. A clear command is taken
// in the idle state and gives no result. A finished result waits in the output
// register while the next item is accepted; a new result that finds the previous
// one still stalled holds the step in its publish state until the output register
// frees up.
//
// Top level; depends on tapp_pkg, tapp_ctrl, tapp_dp and the assertion macros.
`include "three_axis_position_pid_macros.svh"
module three_axis_position_pid #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic signed [31:0] in_measured_x,
  input  logic signed [31:0] in_measured_y,
  input  logic signed [31:0] in_measured_z,
  input  logic [19:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_speed_x,
  output logic signed [31:0] out_speed_y,
  output logic signed [31:0] out_speed_z,
  output logic               out_saturated
);
  import tapp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tapp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  tapp_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_command    (in_command),
    .in_target_x   (in_target_x),
    .in_target_y   (in_target_y),
    .in_target_z   (in_target_z),
    .in_measured_x (in_measured_x),
    .in_measured_y (in_measured_y),
    .in_measured_z (in_measured_z),
    .in_time_step  (in_time_step),
    .out_speed_x   (out_speed_x),
    .out_speed_y   (out_speed_y),
    .out_speed_z   (out_speed_z),
    .out_saturated (out_saturated)
  );

  // A new transfer is never taken while a division is still running.
  `TAPP_ASSERT(a_no_accept_in_div, in_stall || !stat.div_busy, "accept during divide")
  // A division is only started on an idle divider.
  `TAPP_ASSERT(a_div_idle_start, !(cmd.op == OP_DLIM || cmd.op == OP_DD) || !stat.div_busy, "divider restarted while busy")
  // Publishing a result never overwrites one still waiting, and shows it next cycle.
  `TAPP_ASSERT(a_publish_free, cmd.op != OP_PUBLISH || !out_valid || !out_stall, "result overwritten")
  `TAPP_ASSERT_NEXT(a_publish_valid, cmd.op == OP_PUBLISH, out_valid, "published result not shown")

endmodule

// ===== dv/tb_three_axis_position_pid.sv =====
// Testbench for the three-axis position PID: directed and random control steps
// and clears, checked against a behavioral predictor of the fixed-point control law.
// Depends on tapp_pkg and the three_axis_position_pid top level.
`timescale 1ns / 1ps
module tb_three_axis_position_pid;
  import tapp_pkg::*;

  localparam int FB = 16;
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] tx, ty, tz, mx, my, mz;
    logic [19:0]        dt;
  } pos_item_t;

  typedef struct packed {
    logic signed [31:0] sx, sy, sz;
    logic               sat;
  } speed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic signed [31:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic signed [31:0] in_measured_x = '0, in_measured_y = '0, in_measured_z = '0;
  logic [19:0] in_time_step = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_speed_x, out_speed_y, out_speed_z;
  logic out_saturated;

  three_axis_position_pid #(.FRACTION_BITS(FB)) i_dut (.*);

  always #4 clk = ~clk;

  // Predictor state and its copy of the configuration.
  logic [47:0] kp_r, ki_r, kd_r;
  logic [16:0] alpha_r;
  logic [30:0] awl_r;
  longint prev_err [3];
  longint filt_diff [3];
  longint integ [3];
  bit primed;

  pos_item_t pending_items[$];
  speed_t expected_speeds[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  bit in_taken = 0;

  function automatic longint floor_shr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint round_shr(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Appends one item to the tail of the stimulus queue.
  function automatic void add_item(pos_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Advances the predictor by one item; returns 1 when a speed result is produced.
  function automatic bit predict_speed(pos_item_t it, output speed_t res);
    longint lo32, hi32, lo48, hi48, qlim;
    longint err [3];
    longint dt, alpha, kp, ki, kd, e, f, s, lim, p, i, d, num, q, r, tot;
    longint tgt [3], msr [3];
    longint spd [3];
    bit sat;
    lo32 = -(longint'(1) << 31);
    hi32 = (longint'(1) << 31) - 1;
    lo48 = -(longint'(1) << 47);
    hi48 = (longint'(1) << 47) - 1;
    qlim = (longint'(1) << 60) >>> (FB - GAIN_BITS);
    sat = 0;
    res = '0;
    if (it.command == CMD_CLEAR) begin
      for (int a = 0; a < 3; a++) integ[a] = 0;
      return 0;
    end
    dt = longint'(it.dt);
    alpha = longint'(alpha_r);
    if (alpha > 65536) alpha = 65536;
    tgt[0] = it.tx; tgt[1] = it.ty; tgt[2] = it.tz;
    msr[0] = it.mx; msr[1] = it.my; msr[2] = it.mz;
    for (int a = 0; a < 3; a++) err[a] = clip(tgt[a] - msr[a], lo32, hi32);
    if (!primed) begin
      for (int a = 0; a < 3; a++) begin
        prev_err[a] = err[a];
        filt_diff[a] = err[a];
      end
      primed = 1;
    end
    for (int a = 0; a < 3; a++) begin
      kp = longint'(kp_r[16*a +: 16]);
      ki = longint'(ki_r[16*a +: 16]);
      kd = longint'(kd_r[16*a +: 16]);
      e = err[a];
      f = alpha * (e - prev_err[a]) + (65536 - alpha) * filt_diff[a];
      f = clip(round_shr(f, 16), lo32, hi32);
      filt_diff[a] = f;
      prev_err[a] = e;
      s = clip(integ[a] + round_shr(e * dt, FB), lo48, hi48);
      if (ki != 0) begin
        lim = (longint'(awl_r) << GAIN_BITS) / ki;
        s = clip(s, -lim, lim);
      end
      integ[a] = s;
      p = round_shr(kp * e, GAIN_BITS);
      i = round_shr(ki * s, GAIN_BITS);
      d = 0;
      if (dt != 0) begin
        num = kd * f;
        q = clip(num / dt, -qlim, qlim);
        r = num % dt;
        d = q * (longint'(1) << (FB - GAIN_BITS)) + (r * (longint'(1) << (FB - GAIN_BITS))) / dt;
      end
      tot = p + i + d;
      if (tot > hi32 || tot < lo32) sat = 1;
      spd[a] = clip(tot, lo32, hi32);
    end
    res.sx = spd[0][31:0];
    res.sy = spd[1][31:0];
    res.sz = spd[2][31:0];
    res.sat = sat;
    return 1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_val);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
    errors++;
  endtask

  // Records whether the offered input was taken at this rising edge.
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // Driver: offers queued items at the falling edge, holding a stalled transfer.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pos_item_t it;
        speed_t res;
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_command <= it.command;
        in_target_x <= it.tx; in_target_y <= it.ty; in_target_z <= it.tz;
        in_measured_x <= it.mx; in_measured_y <= it.my; in_measured_z <= it.mz;
        in_time_step <= it.dt;
        if (predict_speed(it, res)) expected_speeds.insert(expected_speeds.size(), res);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_speeds.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        speed_t exp_res;
        exp_res = expected_speeds.pop_front();
        if (out_speed_x !== exp_res.sx) report_mismatch("speed_x", out_speed_x, exp_res.sx);
        if (out_speed_y !== exp_res.sy) report_mismatch("speed_y", out_speed_y, exp_res.sy);
        if (out_speed_z !== exp_res.sz) report_mismatch("speed_z", out_speed_z, exp_res.sz);
        if (out_saturated !== exp_res.sat)
          report_mismatch("saturated", out_saturated, exp_res.sat);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_KP: kp_r = val;
      CFG_KI: ki_r = val;
      CFG_KD: kd_r = val;
      CFG_ALPHA: alpha_r = val[16:0];
      CFG_AWL: awl_r = val[30:0];
      default: ;
    endcase
  endtask

  // Waits until every queued item is sent and every result checked, then lets
  // the block finish any clear still in flight.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_speeds.size() > 0)
      @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_pos(int span);
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(2 * span)) - span;
    endcase
  endfunction

  function automatic pos_item_t rand_item(int span);
    pos_item_t it;
    it.command = ($urandom_range(15) == 0) ? CMD_CLEAR : CMD_STEP;
    it.tx = rand_pos(span); it.ty = rand_pos(span); it.tz = rand_pos(span);
    it.mx = rand_pos(span); it.my = rand_pos(span); it.mz = rand_pos(span);
    case ($urandom_range(9))
      0: it.dt = '0;
      1: it.dt = 20'hfffff;
      2: it.dt = 20'($urandom);
      default: it.dt = 20'($urandom_range(200, 3000));
    endcase
    return it;
  endfunction

  function automatic logic [47:0] rand_gains();
    return {16'($urandom_range(0, 1024)), 16'($urandom), 16'($urandom_range(0, 600))};
  endfunction

  function automatic pos_item_t make_item(logic cmd, logic signed [31:0] t, m,
                                          logic [19:0] dt);
    pos_item_t it;
    it.command = cmd;
    it.tx = t; it.ty = -t; it.tz = m;
    it.mx = m; it.my = t; it.mz = t;
    it.dt = dt;
    return it;
  endfunction

  // Stimulus: directed corners, then random phases under changing settings.
  initial begin
    kp_r = 0; ki_r = 0; kd_r = 0; alpha_r = 17'd65536; awl_r = 0;
    for (int a = 0; a < 3; a++) begin
      prev_err[a] = 0; filt_diff[a] = 0; integ[a] = 0;
    end
    primed = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Clear before priming, then first step with reset configuration.
    add_item(make_item(CMD_CLEAR, 32'sd100, 32'sd0, 20'd1000));
    add_item(make_item(CMD_STEP, 32'sd65536, -32'sd65536, 20'd6554));
    drain();
    write_reg(CFG_KP, 48'h0100_ffff_0080);
    write_reg(CFG_KI, 48'h0000_0100_ffff);
    write_reg(CFG_KD, 48'hffff_0040_0200);
    write_reg(CFG_ALPHA, 48'h1ffff);
    write_reg(CFG_AWL, 48'h7fffffff);
    write_reg(3'd7, 48'hffff_ffff_ffff);
    add_item(make_item(CMD_STEP, 32'sh7fffffff, 32'sh80000000, 20'hfffff));
    add_item(make_item(CMD_STEP, 32'sh80000000, 32'sh7fffffff, 20'd0));
    add_item(make_item(CMD_STEP, 32'sd0, 32'sd0, 20'd1));
    add_item(make_item(CMD_STEP, 32'sd12345678, -32'sd5, 20'd65536));
    add_item(make_item(CMD_CLEAR, 32'sd0, 32'sd0, 20'd0));
    add_item(make_item(CMD_STEP, -32'sd1, 32'sd1, 20'd3));
    add_item(make_item(CMD_STEP, 32'sh55555555, 32'shaaaaaaaa, 20'haaaaa));
    add_item(make_item(CMD_STEP, 32'shaaaaaaaa, 32'sh55555555, 20'h55555));
    drain();
    write_reg(CFG_ALPHA, 48'd0);
    write_reg(CFG_AWL, 48'd0);
    add_item(make_item(CMD_STEP, 32'sd655360, 32'sd0, 20'd100));
    add_item(make_item(CMD_STEP, -32'sd655360, 32'sd0, 20'd100));
    drain();

    // Random phases: settings change between phases, idling as prescribed.
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 85 : 0;
      recv_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 25 : 0;
      write_reg(CFG_KP, rand_gains());
      write_reg(CFG_KI, (ph == 1) ? 48'd0 : rand_gains());
      write_reg(CFG_KD, rand_gains());
      write_reg(CFG_ALPHA, (ph == 2) ? 48'd65536 : 48'($urandom_range(0, 70000)));
      write_reg(CFG_AWL, (ph == 3) ? 48'h7fffffff : 48'($urandom_range(0, 1 << 24)));
      for (int n = 0; n < 72; n++) add_item(rand_item(1 << 20));
      if (ph == 4) begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    repeat (1000) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
